FILE: rtl/rfhp_pkg.sv
// rfhp_pkg: shared types and constants for the radio frame header parser
// no dependencies; used by every module of the block
`default_nettype none
package rfhp_pkg;

    localparam int ADDRESS_BYTES = 5;
    localparam int ADDR_W        = 40;
    localparam int ADDR_CNT_W    = (ADDRESS_BYTES > 1) ? $clog2(ADDRESS_BYTES) : 1;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_ADDR_W    = 4;
    localparam int BIT_SEL_W     = 3;

    localparam logic [1:0] REG_EXTRA_BIT = 2'd0;
    localparam logic [1:0] REG_FIRST_BIT = 2'd1;
    localparam logic [1:0] REG_LAST_BIT  = 2'd2;
    localparam logic [1:0] REG_REPLY_BIT = 2'd3;

    localparam logic [BIT_SEL_W-1:0] RST_EXTRA_BIT = 3'd0;
    localparam logic [BIT_SEL_W-1:0] RST_FIRST_BIT = 3'd1;
    localparam logic [BIT_SEL_W-1:0] RST_LAST_BIT  = 3'd2;
    localparam logic [BIT_SEL_W-1:0] RST_REPLY_BIT = 3'd3;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_TRUNC = 1'b1;

    typedef enum logic [2:0] {
        PH_FLAGS  = 3'd0,
        PH_EXTRA  = 3'd1,
        PH_SEQID  = 3'd2,
        PH_SEQNUM = 3'd3,
        PH_REPLY  = 3'd4,
        PH_SRC    = 3'd5,
        PH_DST    = 3'd6,
        PH_DONE   = 3'd7
    } t_phase;

    typedef struct packed {
        logic [BIT_SEL_W-1:0] extra_flags_bit;
        logic [BIT_SEL_W-1:0] first_frame_bit;
        logic [BIT_SEL_W-1:0] last_frame_bit;
        logic [BIT_SEL_W-1:0] reply_bit;
    } t_cfg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        frame_flags;
        logic [7:0]        extra_flags;
        logic [7:0]        seq_id;
        logic [7:0]        seq_number;
        logic [7:0]        reply_to_id;
        logic [ADDR_W-1:0] source_address;
        logic [ADDR_W-1:0] dest_address;
        logic [3:0]        header_length;
        logic              status;
    } t_out_item;

endpackage
`default_nettype wire

FILE: rtl/rfhp_cfg_regs.sv
// rfhp_cfg_regs: apb register file holding the flag bit positions
// depends on rfhp_pkg
`default_nettype none
module rfhp_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rfhp_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [rfhp_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [rfhp_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output rfhp_pkg::t_cfg                         o_cfg
);

    rfhp_pkg::t_cfg             r_cfg;
    rfhp_pkg::t_cfg             n_cfg;
    logic                       wr_en;
    logic [1:0]                 reg_idx;
    logic [rfhp_pkg::BIT_SEL_W-1:0] wr_val;
    logic [rfhp_pkg::BIT_SEL_W-1:0] rd_val;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign wr_val  = pwdata[rfhp_pkg::BIT_SEL_W-1:0];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                rfhp_pkg::REG_EXTRA_BIT: n_cfg.extra_flags_bit = wr_val;
                rfhp_pkg::REG_FIRST_BIT: n_cfg.first_frame_bit = wr_val;
                rfhp_pkg::REG_LAST_BIT:  n_cfg.last_frame_bit  = wr_val;
                rfhp_pkg::REG_REPLY_BIT: n_cfg.reply_bit       = wr_val;
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rfhp_pkg::REG_EXTRA_BIT: rd_val = r_cfg.extra_flags_bit;
            rfhp_pkg::REG_FIRST_BIT: rd_val = r_cfg.first_frame_bit;
            rfhp_pkg::REG_LAST_BIT:  rd_val = r_cfg.last_frame_bit;
            rfhp_pkg::REG_REPLY_BIT: rd_val = r_cfg.reply_bit;
            default:                 rd_val = '0;
        endcase
    end

    assign prdata = {{(rfhp_pkg::CFG_DATA_W - rfhp_pkg::BIT_SEL_W){1'b0}}, rd_val};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.extra_flags_bit <= rfhp_pkg::RST_EXTRA_BIT;
            r_cfg.first_frame_bit <= rfhp_pkg::RST_FIRST_BIT;
            r_cfg.last_frame_bit  <= rfhp_pkg::RST_LAST_BIT;
            r_cfg.reply_bit       <= rfhp_pkg::RST_REPLY_BIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

FILE: rtl/rfhp_in_stage.sv
// rfhp_in_stage: input register between the byte source and the parser
// depends on rfhp_pkg
`default_nettype none
module rfhp_in_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire rfhp_pkg::t_in_item i_in,
    output logic                    o_valid,
    input  wire logic               i_advance,
    output rfhp_pkg::t_in_item      o_item
);

    logic               r_valid;
    logic               n_valid;
    rfhp_pkg::t_in_item r_item;
    logic               load;

    assign o_in_ready = ~r_valid | i_advance;
    assign load       = i_in_valid & o_in_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_in;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

FILE: rtl/rfhp_parser.sv
// rfhp_parser: header field capture state and the result register
// depends on rfhp_pkg
`default_nettype none
module rfhp_parser (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rfhp_pkg::t_cfg     i_cfg,
    input  wire logic               i_valid,
    input  wire rfhp_pkg::t_in_item i_item,
    output logic                    o_advance,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output rfhp_pkg::t_out_item     o_out
);

    rfhp_pkg::t_phase           r_phase, n_phase;
    logic                       r_skip, n_skip;
    logic                       r_seq, n_seq;
    logic [7:0]                 r_flags, n_flags;
    logic [7:0]                 r_extra, n_extra;
    logic [7:0]                 r_seq_id, n_seq_id;
    logic [7:0]                 r_seq_num, n_seq_num;
    logic [7:0]                 r_reply, n_reply;
    logic [rfhp_pkg::ADDR_W-1:0] r_src, n_src;
    logic [rfhp_pkg::ADDR_W-1:0] r_dst, n_dst;
    logic [rfhp_pkg::ADDR_CNT_W-1:0] r_addr_cnt, n_addr_cnt;
    logic [3:0]                 r_count, n_count;
    logic                       r_out_valid, n_out_valid;
    rfhp_pkg::t_out_item        r_out, n_out;
    rfhp_pkg::t_phase           nxt;
    logic                       fire;
    logic                       res_en;
    logic [7:0]                 b;
    logic                       eob;
    logic                       last_addr;

    assign o_advance = ~r_out_valid | i_out_ready;
    assign fire      = i_valid & o_advance;
    assign b         = i_item.in_byte;
    assign eob       = i_item.end_of_buffer;
    assign last_addr = (r_addr_cnt == rfhp_pkg::ADDR_CNT_W'(rfhp_pkg::ADDRESS_BYTES - 1));

    always_comb begin
        n_phase    = r_phase;
        n_skip     = r_skip;
        n_seq      = r_seq;
        n_flags    = r_flags;
        n_extra    = r_extra;
        n_seq_id   = r_seq_id;
        n_seq_num  = r_seq_num;
        n_reply    = r_reply;
        n_src      = r_src;
        n_dst      = r_dst;
        n_addr_cnt = r_addr_cnt;
        n_count    = r_count;
        nxt        = rfhp_pkg::PH_DONE;
        res_en     = 1'b0;
        n_out      = r_out;

        if (fire && r_skip) begin
            if (eob) begin
                n_skip  = 1'b0;
                n_phase = rfhp_pkg::PH_FLAGS;
            end
        end else if (fire) begin
            case (r_phase)
                rfhp_pkg::PH_FLAGS: begin
                    n_flags    = b;
                    n_extra    = '0;
                    n_seq_id   = '0;
                    n_seq_num  = '0;
                    n_reply    = '0;
                    n_src      = '0;
                    n_dst      = '0;
                    n_addr_cnt = '0;
                    n_count    = '0;
                    n_seq      = ~(b[i_cfg.first_frame_bit] & b[i_cfg.last_frame_bit]);
                    nxt        = rfhp_pkg::PH_EXTRA;
                end
                rfhp_pkg::PH_EXTRA: begin
                    n_extra = b;
                    nxt     = rfhp_pkg::PH_SEQID;
                end
                rfhp_pkg::PH_SEQID: begin
                    n_seq_id = b;
                    nxt      = rfhp_pkg::PH_SEQNUM;
                end
                rfhp_pkg::PH_SEQNUM: begin
                    n_seq_num = b;
                    nxt       = rfhp_pkg::PH_REPLY;
                end
                rfhp_pkg::PH_REPLY: begin
                    n_reply = b;
                    nxt     = rfhp_pkg::PH_SRC;
                end
                rfhp_pkg::PH_SRC: begin
                    n_src = {r_src[rfhp_pkg::ADDR_W-9:0], b};
                    if (last_addr) begin
                        n_addr_cnt = '0;
                        nxt        = rfhp_pkg::PH_DST;
                    end else begin
                        n_addr_cnt = r_addr_cnt + 1'b1;
                        nxt        = rfhp_pkg::PH_SRC;
                    end
                end
                rfhp_pkg::PH_DST: begin
                    n_dst = {r_dst[rfhp_pkg::ADDR_W-9:0], b};
                    if (last_addr) begin
                        n_addr_cnt = '0;
                        nxt        = rfhp_pkg::PH_DONE;
                    end else begin
                        n_addr_cnt = r_addr_cnt + 1'b1;
                        nxt        = rfhp_pkg::PH_DST;
                    end
                end
                default: begin
                    nxt = rfhp_pkg::PH_DONE;
                end
            endcase
            n_count = n_count + 4'd1;

            // optional fields fall through in wire order
            if (nxt == rfhp_pkg::PH_EXTRA && !n_flags[i_cfg.extra_flags_bit]) begin
                nxt = rfhp_pkg::PH_SEQID;
            end
            if (nxt == rfhp_pkg::PH_SEQNUM && !n_seq) begin
                nxt = rfhp_pkg::PH_REPLY;
            end
            if (nxt == rfhp_pkg::PH_REPLY && !n_flags[i_cfg.reply_bit]) begin
                nxt = rfhp_pkg::PH_SRC;
            end
            if (nxt == rfhp_pkg::PH_SRC && n_seq && n_seq_num != 8'd0) begin
                nxt = rfhp_pkg::PH_DONE;
            end

            if (nxt == rfhp_pkg::PH_DONE) begin
                res_en               = 1'b1;
                n_out.frame_flags    = n_flags;
                n_out.extra_flags    = n_extra;
                n_out.seq_id         = n_seq_id;
                n_out.seq_number     = n_seq_num;
                n_out.reply_to_id    = n_reply;
                n_out.source_address = n_src;
                n_out.dest_address   = n_dst;
                n_out.header_length  = n_count;
                n_out.status         = rfhp_pkg::STATUS_OK;
                n_phase              = rfhp_pkg::PH_FLAGS;
                n_skip               = ~eob;
            end else if (eob) begin
                res_en       = 1'b1;
                n_out        = '0;
                n_out.status = rfhp_pkg::STATUS_TRUNC;
                n_phase      = rfhp_pkg::PH_FLAGS;
            end else begin
                n_phase = nxt;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_en) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rfhp_pkg::PH_FLAGS;
            r_skip      <= 1'b0;
            r_seq       <= 1'b0;
            r_flags     <= '0;
            r_extra     <= '0;
            r_seq_id    <= '0;
            r_seq_num   <= '0;
            r_reply     <= '0;
            r_src       <= '0;
            r_dst       <= '0;
            r_addr_cnt  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_skip      <= n_skip;
            r_seq       <= n_seq;
            r_flags     <= n_flags;
            r_extra     <= n_extra;
            r_seq_id    <= n_seq_id;
            r_seq_num   <= n_seq_num;
            r_reply     <= n_reply;
            r_src       <= n_src;
            r_dst       <= n_dst;
            r_addr_cnt  <= n_addr_cnt;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

FILE: rtl/radio_frame_header_parser_core.sv
// radio_frame_header_parser_core: top level of the radio frame header parser
// depends on rfhp_pkg, rfhp_cfg_regs, rfhp_in_stage, rfhp_parser
//
// usage
// - bytes of a received buffer enter on the input channel, one item per byte,
//   with end_of_buffer set on the last byte of the buffer
// - one result item leaves per header: either the decoded fields with their
//   header length, or a truncation status when the buffer ends early
// - payload bytes after a header make no result; parsing restarts after the
//   end-marked byte
// - throughput is one byte per cycle while the receiver takes results, set by the
//   single capture step between the input register and the result register
// - an accepted byte passes through the input register and then the result
//   register, which holds its result
// - the apb port holds the four flag bit positions; write it only while idle
// - reset returns the bit positions to their defaults and the parser to
//   expecting a flag byte; no clearing pass is needed
// - when the receiver holds ready low the result holds; one more byte waits in
//   the input register, then input ready drops
`default_nettype none
module radio_frame_header_parser_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire rfhp_pkg::t_in_item                i_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output rfhp_pkg::t_out_item                    o_out,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rfhp_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [rfhp_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [rfhp_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    rfhp_pkg::t_cfg     cfg;
    rfhp_pkg::t_in_item stage_item;
    logic               stage_valid;
    logic               advance;

    rfhp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rfhp_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_valid    (stage_valid),
        .i_advance  (advance),
        .o_item     (stage_item)
    );

    rfhp_parser u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (stage_valid),
        .i_item      (stage_item),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

FILE: tb/radio_frame_header_parser_core_test.sv
// self-checking testbench for radio_frame_header_parser_core: byte stream in,
// decoded header items checked against an in-bench header decoder
// depends on rfhp_pkg and the radio_frame_header_parser_core rtl
`timescale 1ns / 1ps
module radio_frame_header_parser_core_test;

    localparam int DRAIN_CYCLES = 6;
    localparam int AW = rfhp_pkg::ADDR_W;
    localparam int DW = rfhp_pkg::CFG_DATA_W;
    localparam int SW = rfhp_pkg::BIT_SEL_W;

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    rfhp_pkg::t_in_item    in_item = '0;
    logic                  out_ready = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [rfhp_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [DW-1:0]         pwdata = '0;
    wire logic             o_in_ready;
    wire logic             o_out_valid;
    rfhp_pkg::t_out_item   o_out;
    wire logic [DW-1:0]    prdata;
    wire logic             pready;

    rfhp_pkg::t_cfg      flag_pos = '{rfhp_pkg::RST_EXTRA_BIT, rfhp_pkg::RST_FIRST_BIT,
                                      rfhp_pkg::RST_LAST_BIT, rfhp_pkg::RST_REPLY_BIT};
    rfhp_pkg::t_phase    field_pos = rfhp_pkg::PH_FLAGS;
    bit                  seq_mode = 1'b0;
    bit                  skip_payload = 1'b0;
    rfhp_pkg::t_out_item held = '0;
    int                  addr_cnt = 0;
    int                  hdr_cnt = 0;

    rfhp_pkg::t_out_item expected_headers[$];
    rfhp_pkg::t_out_item want;
    int        err_count = 0;
    int        items_sent = 0;
    bit        idle_on = 1'b1;
    int        hold_len = 0;

    radio_frame_header_parser_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(8, 30);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 3) == 0) begin
            return 8'h00;
        end
        if ($urandom_range(0, 5) == 0) begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            return $urandom_range(12, 19);
        end
        if (r < 9) begin
            return $urandom_range(2, 11);
        end
        return 1;
    endfunction

    function automatic logic [SW-1:0] cfg_value(input logic [1:0] idx);
        case (idx)
            rfhp_pkg::REG_EXTRA_BIT: return flag_pos.extra_flags_bit;
            rfhp_pkg::REG_FIRST_BIT: return flag_pos.first_frame_bit;
            rfhp_pkg::REG_LAST_BIT:  return flag_pos.last_frame_bit;
            default:                 return flag_pos.reply_bit;
        endcase
    endfunction

    // advances the header state by one byte; returns 1 when a header item results
    function automatic bit decode_header_byte(input logic [7:0] b, input logic eob,
                                              output rfhp_pkg::t_out_item hdr);
        rfhp_pkg::t_phase nxt;
        hdr = '0;
        nxt = rfhp_pkg::PH_DONE;
        if (skip_payload) begin
            if (eob) begin
                skip_payload = 1'b0;
                field_pos = rfhp_pkg::PH_FLAGS;
            end
            return 1'b0;
        end
        case (field_pos)
            rfhp_pkg::PH_FLAGS: begin
                held = '0;
                addr_cnt = 0;
                hdr_cnt = 0;
                held.frame_flags = b;
                seq_mode = !(b[flag_pos.first_frame_bit] && b[flag_pos.last_frame_bit]);
                nxt = rfhp_pkg::PH_EXTRA;
            end
            rfhp_pkg::PH_EXTRA: begin
                held.extra_flags = b;
                nxt = rfhp_pkg::PH_SEQID;
            end
            rfhp_pkg::PH_SEQID: begin
                held.seq_id = b;
                nxt = rfhp_pkg::PH_SEQNUM;
            end
            rfhp_pkg::PH_SEQNUM: begin
                held.seq_number = b;
                nxt = rfhp_pkg::PH_REPLY;
            end
            rfhp_pkg::PH_REPLY: begin
                held.reply_to_id = b;
                nxt = rfhp_pkg::PH_SRC;
            end
            rfhp_pkg::PH_SRC: begin
                held.source_address = {held.source_address[AW-9:0], b};
                addr_cnt++;
                if (addr_cnt >= rfhp_pkg::ADDRESS_BYTES) begin
                    addr_cnt = 0;
                    nxt = rfhp_pkg::PH_DST;
                end else begin
                    nxt = rfhp_pkg::PH_SRC;
                end
            end
            rfhp_pkg::PH_DST: begin
                held.dest_address = {held.dest_address[AW-9:0], b};
                addr_cnt++;
                if (addr_cnt >= rfhp_pkg::ADDRESS_BYTES) begin
                    addr_cnt = 0;
                    nxt = rfhp_pkg::PH_DONE;
                end else begin
                    nxt = rfhp_pkg::PH_DST;
                end
            end
            default: nxt = rfhp_pkg::PH_DONE;
        endcase
        hdr_cnt++;
        if (nxt == rfhp_pkg::PH_EXTRA && !held.frame_flags[flag_pos.extra_flags_bit])
            nxt = rfhp_pkg::PH_SEQID;
        if (nxt == rfhp_pkg::PH_SEQNUM && !seq_mode) nxt = rfhp_pkg::PH_REPLY;
        if (nxt == rfhp_pkg::PH_REPLY && !held.frame_flags[flag_pos.reply_bit])
            nxt = rfhp_pkg::PH_SRC;
        if (nxt == rfhp_pkg::PH_SRC && seq_mode && held.seq_number != 8'd0)
            nxt = rfhp_pkg::PH_DONE;
        if (nxt == rfhp_pkg::PH_DONE) begin
            hdr = held;
            hdr.header_length = 4'(hdr_cnt);
            hdr.status = rfhp_pkg::STATUS_OK;
            field_pos = rfhp_pkg::PH_FLAGS;
            skip_payload = !eob;
            return 1'b1;
        end
        if (eob) begin
            hdr = '0;
            hdr.status = rfhp_pkg::STATUS_TRUNC;
            field_pos = rfhp_pkg::PH_FLAGS;
            return 1'b1;
        end
        field_pos = nxt;
        return 1'b0;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eob);
        rfhp_pkg::t_out_item hdr;
        in_valid <= 1'b1;
        in_item <= '{in_byte: b, end_of_buffer: eob};
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (decode_header_byte(b, eob, hdr)) expected_headers.push_back(hdr);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat (gap_len()) @(posedge i_clk);
        end
    endtask

    task automatic send_buffer(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(rand_byte(), i == len - 1);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_headers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [1:0] idx,
                            input logic [DW-1:0] wdata,
                            output logic [DW-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input logic [1:0] idx);
        logic [DW-1:0] rd;
        apb_xfer(1'b0, idx, '0, rd);
        if (rd !== DW'(cfg_value(idx))) begin
            $display("%0t: register %0d expected %h got %h", $time, idx,
                     DW'(cfg_value(idx)), rd);
            err_count++;
        end
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [SW-1:0] val);
        logic [DW-1:0] rd;
        apb_xfer(1'b1, idx, DW'(val), rd);
        case (idx)
            rfhp_pkg::REG_EXTRA_BIT: flag_pos.extra_flags_bit = val;
            rfhp_pkg::REG_FIRST_BIT: flag_pos.first_frame_bit = val;
            rfhp_pkg::REG_LAST_BIT:  flag_pos.last_frame_bit = val;
            default:                 flag_pos.reply_bit = val;
        endcase
        check_reg(idx);
    endtask

    task automatic set_all_regs(input rfhp_pkg::t_cfg c);
        set_reg(rfhp_pkg::REG_EXTRA_BIT, c.extra_flags_bit);
        set_reg(rfhp_pkg::REG_FIRST_BIT, c.first_frame_bit);
        set_reg(rfhp_pkg::REG_LAST_BIT, c.last_frame_bit);
        set_reg(rfhp_pkg::REG_REPLY_BIT, c.reply_bit);
    endtask

    function automatic void check_field(input string name, input logic [AW-1:0] e,
                                        input logic [AW-1:0] a);
        if (a !== e) begin
            $display("%0t: %s expected %h got %h", $time, name, e, a);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            if (expected_headers.size() == 0) begin
                $display("%0t: header item with none expected, expected none got %h",
                         $time, o_out);
                err_count++;
            end else begin
                want = expected_headers.pop_front();
                check_field("frame_flags", AW'(want.frame_flags), AW'(o_out.frame_flags));
                check_field("extra_flags", AW'(want.extra_flags), AW'(o_out.extra_flags));
                check_field("seq_id", AW'(want.seq_id), AW'(o_out.seq_id));
                check_field("seq_number", AW'(want.seq_number), AW'(o_out.seq_number));
                check_field("reply_to_id", AW'(want.reply_to_id), AW'(o_out.reply_to_id));
                check_field("source_address", want.source_address, o_out.source_address);
                check_field("dest_address", want.dest_address, o_out.dest_address);
                check_field("header_length", AW'(want.header_length),
                            AW'(o_out.header_length));
                check_field("status", AW'(want.status), AW'(o_out.status));
            end
        end
    end

    // output side: random gaps, or a long hold when one is requested
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_len != 0) begin
                out_ready <= 1'b0;
                n = hold_len;
                hold_len = 0;
                repeat (n) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat (gap_len()) @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic test_register_reset();
        check_reg(rfhp_pkg::REG_EXTRA_BIT);
        check_reg(rfhp_pkg::REG_FIRST_BIT);
        check_reg(rfhp_pkg::REG_LAST_BIT);
        check_reg(rfhp_pkg::REG_REPLY_BIT);
    endtask

    task automatic test_directed_headers();
        // full header with extra flags and reply field, ending on the end-marked byte
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        for (int i = 0; i < rfhp_pkg::ADDRESS_BYTES; i++) send_byte(8'hFF, 1'b0);
        for (int i = 0; i < rfhp_pkg::ADDRESS_BYTES; i++)
            send_byte(8'h00, i == rfhp_pkg::ADDRESS_BYTES - 1);
        // sequence frame with nonzero number, then skipped payload
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hA5, 1'b1);
        // buffer that is only a flag byte
        send_byte(8'h06, 1'b1);
        // sequence number zero with reply, cut short inside the source address
        send_byte(8'h08, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        wait_idle();
    endtask

    task automatic test_config_sweep();
        rfhp_pkg::t_cfg sweep[4];
        sweep[0] = '{3'd0, 3'd0, 3'd0, 3'd0};
        sweep[1] = '{3'd7, 3'd7, 3'd7, 3'd7};
        sweep[2] = '{3'd7, 3'd0, 3'd7, 3'd0};
        sweep[3] = '{3'd5, 3'd6, 3'd6, 3'd4};
        foreach (sweep[k]) begin
            set_all_regs(sweep[k]);
            repeat (12) send_buffer(pick_len());
            wait_idle();
        end
    endtask

    task automatic test_output_stall();
        idle_on = 1'b0;
        hold_len = 80;
        repeat (24) send_byte(8'($urandom_range(0, 255)), 1'b1);
        wait_idle();
        idle_on = 1'b1;
    endtask

    task automatic test_random_frames();
        rfhp_pkg::t_cfg c;
        int target;
        for (int ph = 0; ph < 8; ph++) begin
            c.extra_flags_bit = 3'($urandom_range(0, 7));
            c.first_frame_bit = 3'($urandom_range(0, 7));
            c.last_frame_bit = 3'($urandom_range(0, 7));
            c.reply_bit = 3'($urandom_range(0, 7));
            if (ph == 0) c = '{rfhp_pkg::RST_EXTRA_BIT, rfhp_pkg::RST_FIRST_BIT,
                               rfhp_pkg::RST_LAST_BIT, rfhp_pkg::RST_REPLY_BIT};
            set_all_regs(c);
            idle_on = (ph % 3) != 2;
            target = items_sent + 158;
            while (items_sent < target) send_buffer(pick_len());
            wait_idle();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_reset();
        test_directed_headers();
        test_config_sweep();
        test_output_stall();
        test_random_frames();
        wait_idle();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: radio_frame_header_parser_core.f
rtl/rfhp_pkg.sv
rtl/rfhp_cfg_regs.sv
rtl/rfhp_in_stage.sv
rtl/rfhp_parser.sv
rtl/radio_frame_header_parser_core.sv
tb/radio_frame_header_parser_core_test.sv
